FILE: design/cdq_pkg.sv
// Package for the circular deque: field widths, codes, defaults and shared types.
package cdq_pkg;

  // Fixed field widths of the transfer payloads
  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned DATA_IN_W  = 32;
  localparam int unsigned POSITION_W = 4;
  localparam int unsigned DATA_OUT_W = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;

  // Parameter defaults
  localparam int unsigned DEFAULT_DEPTH      = 16;
  localparam int unsigned DEFAULT_DATA_WIDTH = 32;

  // Operation codes; six and seven are no-ops
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR      = 3'd5
  } opcode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_BAD_IDX = 2'd3
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } cdq_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    take;
    logic    push_back;
    logic    pop_back;
    logic    push_front;
    logic    pop_front;
    logic    rd_pos;
    logic    clear;
    status_e status;
    logic    data_ok;
  } cdq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_bad;
  } cdq_stat_t;

endpackage

FILE: design/cdq_if.sv
// Handshake interfaces for the deque's operation and result channels.
interface cdq_in_if;
  logic                             valid;
  logic                             ready;
  logic [cdq_pkg::OPCODE_W-1:0]     opcode;
  logic [cdq_pkg::DATA_IN_W-1:0]    data_in;
  logic [cdq_pkg::POSITION_W-1:0]   position;

  modport source (output valid, output opcode, output data_in, output position,
                  input ready);
  modport sink   (input valid, input opcode, input data_in, input position,
                  output ready);
endinterface

interface cdq_out_if;
  logic                             valid;
  logic                             ready;
  logic [cdq_pkg::DATA_OUT_W-1:0]   data_out;
  logic [cdq_pkg::STATUS_W-1:0]     status;
  logic [cdq_pkg::COUNT_W-1:0]      count;

  modport source (output valid, output data_out, output status, output count,
                  input ready);
  modport sink   (input valid, input data_out, input status, input count,
                  output ready);
endinterface

FILE: design/cdq_ctrl.sv
// Controller for the circular deque: handshake sequencing and opcode decode.
module cdq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [cdq_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic                          out_ready_i,
  input  cdq_pkg::cdq_stat_t            stat_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  output cdq_pkg::cdq_cmd_t             cmd_o
);

  cdq_pkg::cdq_state_e state_q, state_d;
  logic                take;

  assign take = in_valid_i && (state_q == cdq_pkg::S_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdq_pkg::S_IDLE: begin
        if (in_valid_i) state_d = cdq_pkg::S_RESP;
      end
      cdq_pkg::S_RESP: begin
        if (out_ready_i) state_d = cdq_pkg::S_IDLE;
      end
      default: state_d = cdq_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshake and decoded command
  always_comb begin
    in_ready_o  = (state_q == cdq_pkg::S_IDLE);
    out_valid_o = (state_q == cdq_pkg::S_RESP);
    cmd_o         = '0;
    cmd_o.take    = take;
    cmd_o.status  = cdq_pkg::STAT_OK;
    if (take) begin
      unique case (cdq_pkg::opcode_e'(opcode_i))
        cdq_pkg::OP_PUSH_BACK: begin
          if (stat_i.full) cmd_o.status = cdq_pkg::STAT_FULL;
          else             cmd_o.push_back = 1'b1;
        end
        cdq_pkg::OP_PUSH_FRONT: begin
          if (stat_i.full) cmd_o.status = cdq_pkg::STAT_FULL;
          else             cmd_o.push_front = 1'b1;
        end
        cdq_pkg::OP_POP_BACK: begin
          if (stat_i.empty) begin
            cmd_o.status = cdq_pkg::STAT_EMPTY;
          end else begin
            cmd_o.pop_back = 1'b1;
            cmd_o.data_ok  = 1'b1;
          end
        end
        cdq_pkg::OP_POP_FRONT: begin
          if (stat_i.empty) begin
            cmd_o.status = cdq_pkg::STAT_EMPTY;
          end else begin
            cmd_o.pop_front = 1'b1;
            cmd_o.data_ok   = 1'b1;
          end
        end
        cdq_pkg::OP_READ: begin
          if (stat_i.empty) begin
            cmd_o.status = cdq_pkg::STAT_EMPTY;
          end else if (stat_i.pos_bad) begin
            cmd_o.status = cdq_pkg::STAT_BAD_IDX;
          end else begin
            cmd_o.rd_pos  = 1'b1;
            cmd_o.data_ok = 1'b1;
          end
        end
        cdq_pkg::OP_CLEAR: cmd_o.clear = 1'b1;
        default: ; // unused codes: no operation
      endcase
    end
  end

endmodule

FILE: design/cdq_dpath.sv
// Datapath for the circular deque: entry store, pointers, count and result registers.
module cdq_dpath #(
  parameter int unsigned DEPTH      = cdq_pkg::DEFAULT_DEPTH,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cdq_pkg::cdq_cmd_t                cmd_i,
  input  logic [cdq_pkg::DATA_IN_W-1:0]    data_in_i,
  input  logic [cdq_pkg::POSITION_W-1:0]   position_i,
  output cdq_pkg::cdq_stat_t               stat_o,
  output logic [cdq_pkg::DATA_OUT_W-1:0]   data_out_o,
  output logic [cdq_pkg::STATUS_W-1:0]     status_o,
  output logic [cdq_pkg::COUNT_W-1:0]      count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = cdq_pkg::POSITION_W;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned SUM_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [PTR_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  cdq_pkg::status_e      status_q;
  logic                  data_ok_q;

  logic [PTR_W-1:0]      head_prev, head_next, tail_prev, tail_next;
  logic [SUM_W-1:0]      pos_sum, pos_wrap;
  logic [PTR_W-1:0]      pos_idx, raddr, waddr;
  logic                  we;

  // Circular neighbours of the pointers
  assign head_prev = (head_q == '0)   ? LAST : head_q - 1'b1;
  assign head_next = (head_q == LAST) ? '0   : head_q + 1'b1;
  assign tail_prev = (tail_q == '0)   ? LAST : tail_q - 1'b1;
  assign tail_next = (tail_q == LAST) ? '0   : tail_q + 1'b1;

  // Logical position to slot: sum stays below twice the depth when in range
  assign pos_sum  = SUM_W'(head_q) + SUM_W'(position_i);
  assign pos_wrap = (pos_sum >= SUM_W'(DEPTH)) ? pos_sum - SUM_W'(DEPTH) : pos_sum;
  assign pos_idx  = pos_wrap[PTR_W-1:0];

  // Status to the controller
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.full    = (count_q == CNT_W'(DEPTH));
  assign stat_o.pos_bad = (CMP_W'(position_i) >= CMP_W'(count_q));

  // Store addressing
  assign we    = cmd_i.push_back || cmd_i.push_front;
  assign waddr = cmd_i.push_front ? head_prev : tail_q;

  always_comb begin
    priority if (cmd_i.pop_back) begin
      raddr = tail_prev;
    end else if (cmd_i.pop_front) begin
      raddr = head_q;
    end else begin
      raddr = pos_idx;
    end
  end

  // Entry store with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= DATA_WIDTH'(data_in_i);
    end
    if (cmd_i.pop_back || cmd_i.pop_front || cmd_i.rd_pos) begin
      rd_q <= mem[raddr];
    end
  end

  // Pointer and count next values
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    priority if (cmd_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (cmd_i.push_back) begin
      tail_d  = tail_next;
      count_d = count_q + 1'b1;
    end else if (cmd_i.push_front) begin
      head_d  = head_prev;
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop_back) begin
      tail_d  = tail_prev;
      count_d = count_q - 1'b1;
    end else if (cmd_i.pop_front) begin
      head_d  = head_next;
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Result fields, held while the result transfer stalls
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      status_q  <= cmd_i.status;
      data_ok_q <= cmd_i.data_ok;
    end
  end

  assign data_out_o = data_ok_q ? cdq_pkg::DATA_OUT_W'(rd_q) : '0;
  assign status_o   = status_q;
  assign count_o    = cdq_pkg::COUNT_W'(count_q);

endmodule

FILE: design/circular_deque_top.sv
// Top level of the circular deque: controller plus datapath behind two handshake channels.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    opcode[2:0], data_in[31:0], position[3:0]
//   out_o    out  valid/ready    data_out[31:0], status[1:0], count[4:0]
//
// Each operation runs as the transfer in, then the result from the registered store
// read in the next cycle. One operation is in flight at a time; a new one is taken
// in the cycle after the result transfer.
// A stalled result holds its fields and blocks the input channel.
// Reset empties the deque at once; the store contents are left undefined.
module circular_deque_top #(
  parameter int unsigned DEPTH      = cdq_pkg::DEFAULT_DEPTH,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdq_in_if.sink     in_i,
  cdq_out_if.source  out_o
);

  cdq_pkg::cdq_cmd_t  cmd;
  cdq_pkg::cdq_stat_t stat;

  // Sequencing and decode
  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (in_i.opcode),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // Store, pointers and result registers
  cdq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .data_in_i  (in_i.data_in),
    .position_i (in_i.position),
    .stat_o     (stat),
    .data_out_o (out_o.data_out),
    .status_o   (out_o.status),
    .count_o    (out_o.count)
  );

endmodule
